// ===== rtl/otsr_pkg.sv =====
// otsr_pkg: shared types, register indexes and reset values for the
// on-off-keying tone slot receiver. No dependencies.
`timescale 1ns / 1ps

package otsr_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int EDGE_IN_W   = 4;
    localparam int MS_W        = 8;
    localparam int EDGES_W     = 16;
    localparam int SLOTS_W     = 4;
    localparam int BYTE_W      = 8;
    localparam int STATE_W     = 2;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_SLOT_MS        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HUNT_MS        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HUNT_EDGE_MIN  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TONE_THRESHOLD = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PREAMBLE_SLOTS = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BIT_SLOTS      = 3'd5;

    // register reset values
    localparam logic [MS_W-1:0]    RST_SLOT_MS        = 8'd20;
    localparam logic [MS_W-1:0]    RST_HUNT_MS        = 8'd5;
    localparam logic [EDGES_W-1:0] RST_HUNT_EDGE_MIN  = 16'd20;
    localparam logic [EDGES_W-1:0] RST_TONE_THRESHOLD = 16'd100;
    localparam logic [SLOTS_W-1:0] RST_PREAMBLE_SLOTS = 4'd4;
    localparam logic [SLOTS_W-1:0] RST_BIT_SLOTS      = 4'd8;

    // codes shown on the receiver_state output
    localparam logic [STATE_W-1:0] RS_HUNT     = 2'd0;
    localparam logic [STATE_W-1:0] RS_PREAMBLE = 2'd1;
    localparam logic [STATE_W-1:0] RS_BITS     = 2'd2;

    localparam logic [SLOTS_W-1:0] BYTE_BITS = 4'd8;

    typedef enum logic [2:0] {
        PH_HUNT     = 3'b001,
        PH_PREAMBLE = 3'b010,
        PH_BITS     = 3'b100
    } t_phase;

    typedef struct packed {
        logic [MS_W-1:0]    slot_ms;
        logic [MS_W-1:0]    hunt_ms;
        logic [EDGES_W-1:0] hunt_edge_min;
        logic [EDGES_W-1:0] tone_threshold;
        logic [SLOTS_W-1:0] preamble_slots;
        logic [SLOTS_W-1:0] bit_slots;
    } t_cfg;

    typedef struct packed {
        t_phase             phase;
        logic               window_open;
        logic [MS_W-1:0]    elapsed_ms;
        logic [EDGES_W-1:0] edges;
        logic [SLOTS_W-1:0] slot_counter;
        logic [BYTE_W-1:0]  shift_byte;
    } t_rx_state;

    typedef struct packed {
        logic               byte_valid;
        logic [BYTE_W-1:0]  rx_byte;
        logic [STATE_W-1:0] receiver_state;
    } t_result;

    function automatic logic [STATE_W-1:0] phase_code(input t_phase ph);
        logic [STATE_W-1:0] code;
        unique case (ph)
            PH_PREAMBLE: code = RS_PREAMBLE;
            PH_BITS:     code = RS_BITS;
            default:     code = RS_HUNT;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/otsr_cfg_regs.sv =====
// otsr_cfg_regs: configuration register file of the tone slot receiver.
// Depends on otsr_pkg for register indexes, reset values and t_cfg.
`timescale 1ns / 1ps

module otsr_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_wr_en,
    input  logic [otsr_pkg::CFG_INDEX_W-1:0]   i_wr_index,
    input  logic [otsr_pkg::CFG_DATA_W-1:0]    i_wr_data,
    output otsr_pkg::t_cfg                     o_cfg
);

    otsr_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slot_ms        <= otsr_pkg::RST_SLOT_MS;
            r_cfg.hunt_ms        <= otsr_pkg::RST_HUNT_MS;
            r_cfg.hunt_edge_min  <= otsr_pkg::RST_HUNT_EDGE_MIN;
            r_cfg.tone_threshold <= otsr_pkg::RST_TONE_THRESHOLD;
            r_cfg.preamble_slots <= otsr_pkg::RST_PREAMBLE_SLOTS;
            r_cfg.bit_slots      <= otsr_pkg::RST_BIT_SLOTS;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                otsr_pkg::REG_SLOT_MS:
                    r_cfg.slot_ms <= i_wr_data[otsr_pkg::MS_W-1:0];
                otsr_pkg::REG_HUNT_MS:
                    r_cfg.hunt_ms <= i_wr_data[otsr_pkg::MS_W-1:0];
                otsr_pkg::REG_HUNT_EDGE_MIN:
                    r_cfg.hunt_edge_min <= i_wr_data[otsr_pkg::EDGES_W-1:0];
                otsr_pkg::REG_TONE_THRESHOLD:
                    r_cfg.tone_threshold <= i_wr_data[otsr_pkg::EDGES_W-1:0];
                otsr_pkg::REG_PREAMBLE_SLOTS:
                    r_cfg.preamble_slots <= i_wr_data[otsr_pkg::SLOTS_W-1:0];
                otsr_pkg::REG_BIT_SLOTS:
                    r_cfg.bit_slots <= i_wr_data[otsr_pkg::SLOTS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/otsr_step.sv =====
// otsr_step: next-state and result logic for one input beat of the
// receiver (hunt, preamble, bit phases). Depends on otsr_pkg.
`timescale 1ns / 1ps

module otsr_step (
    input  otsr_pkg::t_cfg                    i_cfg,
    input  otsr_pkg::t_rx_state               i_state,
    input  logic [otsr_pkg::EDGE_IN_W-1:0]    i_edge_count,
    input  logic                              i_ms_tick,
    output otsr_pkg::t_rx_state               o_state,
    output otsr_pkg::t_result                 o_result
);

    localparam int MS_W    = otsr_pkg::MS_W;
    localparam int EDGES_W = otsr_pkg::EDGES_W;
    localparam int SLOTS_W = otsr_pkg::SLOTS_W;
    localparam int BYTE_W  = otsr_pkg::BYTE_W;

    logic [MS_W:0]       ms_sum;
    logic [EDGES_W:0]    edge_sum;
    logic [MS_W-1:0]     el;
    logic [EDGES_W-1:0]  ed;
    logic [MS_W-1:0]     w_el;
    logic [EDGES_W-1:0]  w_ed;
    logic [SLOTS_W-1:0]  sc_inc;
    logic [BYTE_W-1:0]   bit_mask;
    logic [BYTE_W-1:0]   shift_new;
    logic                tone;
    otsr_pkg::t_rx_state n_st;
    logic                valid;
    logic [BYTE_W-1:0]   byte_out;

    // saturating window counters
    assign ms_sum   = {1'b0, i_state.elapsed_ms} + {{MS_W{1'b0}}, i_ms_tick};
    assign edge_sum = {1'b0, i_state.edges}
                    + {{(EDGES_W+1-otsr_pkg::EDGE_IN_W){1'b0}}, i_edge_count};
    assign el = ms_sum[MS_W] ? {MS_W{1'b1}} : ms_sum[MS_W-1:0];
    assign ed = edge_sum[EDGES_W] ? {EDGES_W{1'b1}} : edge_sum[EDGES_W-1:0];

    // a bit window that opens on this beat starts from zero
    assign w_el = i_state.window_open ? el : '0;
    assign w_ed = i_state.window_open ? ed : '0;

    assign sc_inc   = i_state.slot_counter + SLOTS_W'(1);
    assign tone     = w_ed >= i_cfg.tone_threshold;
    assign bit_mask = (tone && (i_state.slot_counter < otsr_pkg::BYTE_BITS))
                    ? (8'h80 >> i_state.slot_counter[2:0]) : '0;
    assign shift_new = i_state.shift_byte | bit_mask;

    always_comb begin
        n_st            = i_state;
        n_st.elapsed_ms = el;
        n_st.edges      = ed;
        valid           = 1'b0;
        byte_out        = '0;
        unique case (i_state.phase)
            otsr_pkg::PH_PREAMBLE: begin
                n_st.window_open = 1'b1;
                if (el >= i_cfg.slot_ms) begin
                    if (ed >= i_cfg.tone_threshold) begin
                        n_st.slot_counter = sc_inc;
                        n_st.elapsed_ms   = '0;
                        n_st.edges        = '0;
                        // zero preamble slots acts like one
                        if (sc_inc >= i_cfg.preamble_slots) begin
                            n_st.phase        = otsr_pkg::PH_BITS;
                            n_st.window_open  = 1'b0;
                            n_st.slot_counter = '0;
                        end
                    end else begin
                        n_st.phase        = otsr_pkg::PH_HUNT;
                        n_st.window_open  = 1'b0;
                        n_st.slot_counter = '0;
                    end
                end
            end
            otsr_pkg::PH_BITS: begin
                n_st.window_open = 1'b1;
                n_st.elapsed_ms  = w_el;
                n_st.edges       = w_ed;
                if (w_el >= i_cfg.slot_ms) begin
                    if (sc_inc >= i_cfg.bit_slots) begin
                        valid             = 1'b1;
                        byte_out          = shift_new;
                        n_st.phase        = otsr_pkg::PH_HUNT;
                        n_st.window_open  = 1'b0;
                        n_st.slot_counter = '0;
                        n_st.shift_byte   = '0;
                    end else begin
                        n_st.shift_byte   = shift_new;
                        n_st.slot_counter = sc_inc;
                        n_st.elapsed_ms   = '0;
                        n_st.edges        = '0;
                    end
                end
            end
            default: begin
                n_st.phase = otsr_pkg::PH_HUNT;
                if (!i_state.window_open) begin
                    n_st.window_open = 1'b1;
                    n_st.elapsed_ms  = '0;
                    n_st.edges       = '0;
                end else if (el >= i_cfg.hunt_ms) begin
                    // window time and edges carry into the first preamble slot
                    if (ed >= i_cfg.hunt_edge_min) begin
                        n_st.phase = otsr_pkg::PH_PREAMBLE;
                    end
                    n_st.window_open = 1'b0;
                end
            end
        endcase
    end

    assign o_state                 = n_st;
    assign o_result.byte_valid     = valid;
    assign o_result.rx_byte        = byte_out;
    assign o_result.receiver_state = otsr_pkg::phase_code(n_st.phase);

endmodule

// ===== rtl/ook_tone_slot_receiver.sv =====
// ook_tone_slot_receiver: top level of the on-off-keying receiver with
// preamble. Depends on otsr_pkg, otsr_cfg_regs and otsr_step.
//
// Usage:
//   input channel  : i_in_valid / o_in_ready, fields i_edge_count, i_ms_tick.
//                    one beat per pin-sampler interval.
//   output channel : o_out_valid / i_out_ready, fields o_byte_valid,
//                    o_rx_byte (zero unless o_byte_valid), o_receiver_state.
//                    exactly one result beat per input beat, in order.
//   config channel : i_cfg_valid / o_cfg_ready (always ready), i_cfg_index,
//                    i_cfg_data; indexes 0..5 are slot_ms, hunt_ms,
//                    hunt_edge_min, tone_threshold, preamble_slots,
//                    bit_slots; other indexes are ignored. write only when idle.
//   path           : input beat into the input register, then receiver state
//                    update into the result register.
//   throughput     : 1 beat per cycle while result beats are taken; the receiver
//                    state update is combinational counter adds and threshold compares.
//   reset          : synchronous, active low; registers take their defaults,
//                    the receiver returns to hunt, both stages empty.
//   stall          : while the result waits, the input register still takes
//                    one more beat; after that o_in_ready drops until the
//                    result beat is taken.
`timescale 1ns / 1ps

module ook_tone_slot_receiver (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [otsr_pkg::EDGE_IN_W-1:0]     i_edge_count,
    input  logic                               i_ms_tick,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_byte_valid,
    output logic [otsr_pkg::BYTE_W-1:0]        o_rx_byte,
    output logic [otsr_pkg::STATE_W-1:0]       o_receiver_state,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [otsr_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [otsr_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    otsr_pkg::t_cfg      cfg;
    otsr_pkg::t_rx_state r_state;
    otsr_pkg::t_rx_state n_state;
    otsr_pkg::t_result   n_result;
    otsr_pkg::t_result   r_result;

    logic                              r_s1_valid;
    logic [otsr_pkg::EDGE_IN_W-1:0]    r_s1_edges;
    logic                              r_s1_tick;
    logic                              r_out_valid;
    logic                              s1_move;
    logic                              in_take;

    assign o_cfg_ready = 1'b1;

    otsr_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    otsr_step u_step (
        .i_cfg        (cfg),
        .i_state      (r_state),
        .i_edge_count (r_s1_edges),
        .i_ms_tick    (r_s1_tick),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    // stage 1 hands its beat on when the result register is free or draining
    assign s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_move;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_edges <= i_edge_count;
            r_s1_tick  <= i_ms_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase        <= otsr_pkg::PH_HUNT;
            r_state.window_open  <= 1'b0;
            r_state.elapsed_ms   <= '0;
            r_state.edges        <= '0;
            r_state.slot_counter <= '0;
            r_state.shift_byte   <= '0;
        end else if (s1_move) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_byte_valid     = r_result.byte_valid;
    assign o_rx_byte        = r_result.rx_byte;
    assign o_receiver_state = r_result.receiver_state;

endmodule

// ===== rtl/otsr_checker.sv =====
// otsr_checker: port-level assertions for ook_tone_slot_receiver, bound
// to the top level. Depends on otsr_pkg.
`timescale 1ns / 1ps

module otsr_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic                              o_byte_valid,
    input logic [otsr_pkg::BYTE_W-1:0]       o_rx_byte,
    input logic [otsr_pkg::STATE_W-1:0]      o_receiver_state
);

    // an idle result carries a zero byte
    a_idle_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_byte_valid) |-> (o_rx_byte == '0))
        else $error("rx_byte nonzero without byte_valid");

    // a finished byte always drops the receiver back to hunt
    a_byte_ends_in_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_byte_valid) |-> (o_receiver_state == otsr_pkg::RS_HUNT))
        else $error("byte completed outside hunt");

    // receiver state code three never shows
    a_state_code_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_receiver_state == otsr_pkg::RS_HUNT
                      || o_receiver_state == otsr_pkg::RS_PREAMBLE
                      || o_receiver_state == otsr_pkg::RS_BITS))
        else $error("illegal receiver state code");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_byte_valid)
            && $stable(o_rx_byte) && $stable(o_receiver_state)))
        else $error("result beat changed while stalled");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind ook_tone_slot_receiver otsr_checker u_otsr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_byte_valid     (o_byte_valid),
    .o_rx_byte        (o_rx_byte),
    .o_receiver_state (o_receiver_state)
);

// ===== tb/ook_tone_slot_receiver_tb.sv =====
// ook_tone_slot_receiver_tb: self-checking bench for the on-off-keying tone slot receiver.
// Depends on otsr_pkg and ook_tone_slot_receiver; a scoreboard class tracks the receiver
// state per input beat and checks every result beat in order.
`timescale 1ns / 1ps

module ook_tone_slot_receiver_tb;

    localparam int CFG_INDEX_W = otsr_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W  = otsr_pkg::CFG_DATA_W;
    localparam int EDGE_IN_W   = otsr_pkg::EDGE_IN_W;
    localparam int MS_W        = otsr_pkg::MS_W;
    localparam int EDGES_W     = otsr_pkg::EDGES_W;
    localparam int SLOTS_W     = otsr_pkg::SLOTS_W;
    localparam int BYTE_W      = otsr_pkg::BYTE_W;
    localparam int STATE_W     = otsr_pkg::STATE_W;

    localparam int HOLD_CYCLES  = 200;
    localparam int MAX_SHOWN    = 10;
    localparam int RANDOM_BEATS = 540;

    class rx_scoreboard;
        otsr_pkg::t_cfg     cfg;
        logic [STATE_W-1:0] phase;
        logic               win_open;
        logic [MS_W-1:0]    win_ms;
        logic [EDGES_W-1:0] win_edges;
        logic [SLOTS_W-1:0] slot_cnt;
        logic [BYTE_W-1:0]  shift;
        otsr_pkg::t_result  due_results[$];
        int                 errors;
        int                 checked;
        int                 bytes_seen;

        function new();
            cfg.slot_ms        = otsr_pkg::RST_SLOT_MS;
            cfg.hunt_ms        = otsr_pkg::RST_HUNT_MS;
            cfg.hunt_edge_min  = otsr_pkg::RST_HUNT_EDGE_MIN;
            cfg.tone_threshold = otsr_pkg::RST_TONE_THRESHOLD;
            cfg.preamble_slots = otsr_pkg::RST_PREAMBLE_SLOTS;
            cfg.bit_slots      = otsr_pkg::RST_BIT_SLOTS;
            phase      = otsr_pkg::RS_HUNT;
            win_open   = 1'b0;
            win_ms     = '0;
            win_edges  = '0;
            slot_cnt   = '0;
            shift      = '0;
            errors     = 0;
            checked    = 0;
            bytes_seen = 0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= MAX_SHOWN) begin
                $display("[%0t] mismatch: %s", $time, msg);
            end
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                otsr_pkg::REG_SLOT_MS:        cfg.slot_ms        = data[MS_W-1:0];
                otsr_pkg::REG_HUNT_MS:        cfg.hunt_ms        = data[MS_W-1:0];
                otsr_pkg::REG_HUNT_EDGE_MIN:  cfg.hunt_edge_min  = data[EDGES_W-1:0];
                otsr_pkg::REG_TONE_THRESHOLD: cfg.tone_threshold = data[EDGES_W-1:0];
                otsr_pkg::REG_PREAMBLE_SLOTS: cfg.preamble_slots = data[SLOTS_W-1:0];
                otsr_pkg::REG_BIT_SLOTS:      cfg.bit_slots      = data[SLOTS_W-1:0];
                default: ;
            endcase
        endfunction

        // one receiver step per accepted input beat
        function void step_receiver(logic [EDGE_IN_W-1:0] edges, logic tick);
            otsr_pkg::t_result res;
            int unsigned       ms_sum;
            int unsigned       edge_sum;
            res      = '0;
            ms_sum   = 32'(win_ms) + 32'(tick);
            edge_sum = 32'(win_edges) + 32'(edges);
            win_ms    = (ms_sum > 255) ? 8'hFF : MS_W'(ms_sum);
            win_edges = (edge_sum > 65535) ? 16'hFFFF : EDGES_W'(edge_sum);
            case (phase)
                otsr_pkg::RS_PREAMBLE: begin
                    win_open = 1'b1;
                    if (win_ms >= cfg.slot_ms) begin
                        if (win_edges >= cfg.tone_threshold) begin
                            slot_cnt  = slot_cnt + SLOTS_W'(1);
                            win_ms    = '0;
                            win_edges = '0;
                            if (slot_cnt >= cfg.preamble_slots) begin
                                phase    = otsr_pkg::RS_BITS;
                                win_open = 1'b0;
                                slot_cnt = '0;
                            end
                        end else begin
                            phase    = otsr_pkg::RS_HUNT;
                            slot_cnt = '0;
                            win_open = 1'b0;
                        end
                    end
                end
                otsr_pkg::RS_BITS: begin
                    if (!win_open) begin
                        win_open  = 1'b1;
                        win_ms    = '0;
                        win_edges = '0;
                    end
                    if (win_ms >= cfg.slot_ms) begin
                        // slots past the eighth shift in nothing
                        if (win_edges >= cfg.tone_threshold
                                && slot_cnt < otsr_pkg::BYTE_BITS) begin
                            shift[3'd7 - slot_cnt[2:0]] = 1'b1;
                        end
                        slot_cnt = slot_cnt + SLOTS_W'(1);
                        if (slot_cnt >= cfg.bit_slots) begin
                            res.byte_valid = 1'b1;
                            res.rx_byte    = shift;
                            phase    = otsr_pkg::RS_HUNT;
                            slot_cnt = '0;
                            win_open = 1'b0;
                            shift    = '0;
                        end else begin
                            win_ms    = '0;
                            win_edges = '0;
                        end
                    end
                end
                default: begin
                    phase = otsr_pkg::RS_HUNT;
                    if (!win_open) begin
                        win_open  = 1'b1;
                        win_ms    = '0;
                        win_edges = '0;
                    end else if (win_ms >= cfg.hunt_ms) begin
                        // hunt time and edges stay in the window for the first preamble slot
                        if (win_edges >= cfg.hunt_edge_min) begin
                            phase = otsr_pkg::RS_PREAMBLE;
                        end
                        win_open = 1'b0;
                    end
                end
            endcase
            res.receiver_state = phase;
            due_results.push_back(res);
        endfunction

        function void check_result(logic bv, logic [BYTE_W-1:0] rb, logic [STATE_W-1:0] rs);
            otsr_pkg::t_result want;
            checked++;
            if (due_results.size() == 0) begin
                flag($sformatf("unexpected result valid=%0b byte=%02h state=%0d", bv, rb, rs));
                return;
            end
            want = due_results.pop_front();
            if (want.byte_valid !== bv || want.rx_byte !== rb || want.receiver_state !== rs) begin
                flag($sformatf("result %0d: expected valid=%0b byte=%02h state=%0d, got %0b %02h %0d",
                    checked, want.byte_valid, want.rx_byte, want.receiver_state, bv, rb, rs));
            end else if (bv) begin
                bytes_seen++;
            end
        endfunction
    endclass

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_in_valid   = 1'b0;
    logic [EDGE_IN_W-1:0]   i_edge_count = '0;
    logic                   i_ms_tick    = 1'b0;
    logic                   i_out_ready  = 1'b0;
    logic                   i_cfg_valid  = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data   = '0;
    logic                   o_in_ready;
    logic                   o_out_valid;
    logic                   o_byte_valid;
    logic [BYTE_W-1:0]      o_rx_byte;
    logic [STATE_W-1:0]     o_receiver_state;
    logic                   o_cfg_ready;

    bit           calm           = 1'b0;
    bit           hold_request   = 1'b0;
    int           sent_beats     = 0;
    int           settings_used  = 0;
    rx_scoreboard sb             = new();

    ook_tone_slot_receiver i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_edge_count     (i_edge_count),
        .i_ms_tick        (i_ms_tick),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_byte_valid     (o_byte_valid),
        .o_rx_byte        (o_rx_byte),
        .o_receiver_state (o_receiver_state),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 15);
        if (r < 9) return 0;
        if (r < 15) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [EDGE_IN_W-1:0] tone_edges(logic tone);
        if (tone) return EDGE_IN_W'($urandom_range(6, 15));
        return EDGE_IN_W'($urandom_range(0, 3) == 0);
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_register(index, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // unused upper data bits carry junk, sometimes a spare index is hit too
    task automatic apply_config(input int s, input int h, input int ht, input int tt,
                                input int ps, input int bs);
        write_reg(otsr_pkg::REG_SLOT_MS,        {8'($urandom), 8'(s)});
        write_reg(otsr_pkg::REG_HUNT_MS,        {8'($urandom), 8'(h)});
        write_reg(otsr_pkg::REG_HUNT_EDGE_MIN,  16'(ht));
        write_reg(otsr_pkg::REG_TONE_THRESHOLD, 16'(tt));
        write_reg(otsr_pkg::REG_PREAMBLE_SLOTS, {12'($urandom), 4'(ps)});
        write_reg(otsr_pkg::REG_BIT_SLOTS,      {12'($urandom), 4'(bs)});
        if ($urandom_range(0, 1) == 0) begin
            write_reg(otsr_pkg::REG_BIT_SLOTS + 3'($urandom_range(1, 2)), 16'($urandom));
        end
        settings_used++;
    endtask

    task automatic send_item(input logic [EDGE_IN_W-1:0] edges, input logic tick);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_edge_count <= edges;
        i_ms_tick    <= tick;
        do @(posedge i_clk); while (!o_in_ready);
        sb.step_receiver(edges, tick);
        sent_beats++;
        @(negedge i_clk);
    endtask

    // one millisecond of tone or silence: a few beats, the last carrying the tick
    task automatic send_ms(input logic tone);
        repeat ($urandom_range(0, 2)) send_item(tone_edges(tone), 1'b0);
        send_item(tone_edges(tone), 1'b1);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_byte_valid, o_rx_byte, o_receiver_state);
        end
    end

    initial begin : result_sink
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                stall = pick_gap();
                i_out_ready <= (stall == 0);
                if (stall > 0) stall--;
            end
        end
    end

    initial begin : stimulus
        int         start_beats, phase_start, setting_no;
        int         lead, slot_len, hunt_len, nbits, b, k;
        int         s, h;
        logic [7:0] data;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: a hunt window of five ticks leads into preamble
        send_item(4'd0, 1'b0);
        repeat (5) send_item(4'd15, 1'b1);
        send_item(4'd15, 1'b0);
        send_item(4'd0, 1'b1);
        settle();

        // zero lengths and counts: every window closes on its first check
        apply_config(0, 0, 0, 0, 0, 0);
        send_item(4'd15, 1'b1);
        send_item(4'd0, 1'b0);
        send_item(4'd0, 1'b0);
        send_item(4'd0, 1'b1);
        settle();

        // hunt edges must carry into the first preamble slot to pass it
        apply_config(2, 1, 10, 20, 1, 15);
        send_item(4'd0, 1'b1);
        send_item(4'd0, 1'b0);
        send_item(4'd12, 1'b1);
        send_item(4'd9, 1'b1);
        settle();

        // nine bit slots with zero slot length, the ninth adds no bit
        apply_config(0, 1, 10, 1, 1, 9);
        send_item(4'd15, 1'b0); send_item(4'd15, 1'b0); send_item(4'd0, 1'b0);
        send_item(4'd15, 1'b0); send_item(4'd1, 1'b0);  send_item(4'd0, 1'b0);
        send_item(4'd15, 1'b0); send_item(4'd0, 1'b0);  send_item(4'd15, 1'b0);
        settle();

        // random part: mostly shaped frames, some noise and cut-short preambles
        start_beats = sent_beats;
        setting_no  = 0;
        while (sent_beats - start_beats < RANDOM_BEATS) begin
            settle();
            if (setting_no == 0) begin
                apply_config(1, 1, 0, 0, 1, 1);
            end else if (setting_no == 1) begin
                apply_config(1, 1, 8, 12, 15, 15);
            end else begin
                s = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
                h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
                apply_config(s, h,
                    ((h == 0) ? 1 : h) * $urandom_range(2, 12),
                    ((s == 0) ? 1 : s) * $urandom_range(3, 12),
                    ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4),
                    ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8));
            end
            calm = (setting_no != 2) && ($urandom_range(0, 4) == 0);
            // long receiver hold-off while beats keep coming
            if (setting_no == 2) hold_request = 1'b1;
            phase_start = sent_beats;
            while (sent_beats - phase_start < 70) begin
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(3, 12)) begin
                        send_item(EDGE_IN_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
                    end
                end else begin
                    slot_len = (sb.cfg.slot_ms == 0) ? 1 : sb.cfg.slot_ms;
                    hunt_len = (sb.cfg.hunt_ms == 0) ? 1 : sb.cfg.hunt_ms;
                    lead = hunt_len + $urandom_range(0, slot_len)
                         + ((sb.cfg.preamble_slots == 0) ? 1 : sb.cfg.preamble_slots) * slot_len;
                    if ($urandom_range(0, 4) == 0) lead = $urandom_range(1, lead);
                    nbits = (sb.cfg.bit_slots == 0) ? 1 : sb.cfg.bit_slots;
                    data  = 8'($urandom);
                    repeat (lead) send_ms(1'b1);
                    for (b = 0; b < nbits; b++) begin
                        repeat (slot_len) send_ms((b < 8) ? data[7 - b] : 1'($urandom_range(0, 1)));
                    end
                    repeat ($urandom_range(1, hunt_len + 2 * slot_len)) send_ms(1'b0);
                end
            end
            setting_no++;
        end

        i_in_valid <= 1'b0;
        calm = 1'b0;
        k = 0;
        while (sb.pending() != 0 && k < 5000) begin
            @(posedge i_clk);
            k++;
        end
        if (sb.pending() != 0) begin
            sb.flag($sformatf("%0d results never arrived", sb.pending()));
        end
        repeat (8) @(posedge i_clk);
        $display("sent %0d input beats under %0d register settings, checked %0d result beats",
            sent_beats, settings_used, sb.checked);
        $display("%0d bytes received correctly, %0d mismatches", sb.bytes_seen, sb.errors);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
